### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile the checks out

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)

`define ASSERT_NEVER(name, clk, rst_n, expr, msg)

`endif

`endif

### rtl/core/tlsalpn_pkg.sv
// shared types and protocol constants for the server hello / alpn parser
// no dependencies
`default_nettype none

package tlsalpn_pkg;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_HELLO = 2'd1,
    KIND_ALERT = 2'd2
  } reply_kind_e;

  typedef struct packed {
    logic        valid;
    reply_kind_e kind;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
  } reply_sum_t;

  // record bytes
  localparam logic [7:0] REC_HANDSHAKE = 8'h16;
  localparam logic [7:0] REC_ALERT     = 8'h15;
  localparam logic [7:0] REC_VER_TLS   = 8'h03;
  localparam logic [7:0] REC_VER_SSL   = 8'h02;
  localparam logic [7:0] HS_SERVER_HELLO = 8'h02;
  localparam logic [15:0] EXT_TYPE_ALPN = 16'h0010;

  // byte positions in the reply
  localparam int unsigned POS_REC_TYPE = 0;
  localparam int unsigned POS_REC_VER  = 1;
  localparam int unsigned POS_HS_TYPE  = 5;
  localparam int unsigned POS_VER_MAJ  = 9;
  localparam int unsigned POS_VER_MIN  = 10;
  localparam int unsigned POS_SID_LEN  = 43;
  localparam int unsigned SID_TO_LIST  = 47;

  // length limits
  localparam int unsigned MIN_HELLO_BYTES = 11;
  localparam int unsigned MIN_ALERT_BYTES = 2;
  localparam int unsigned MIN_EXT_BYTES   = 48;
  localparam int unsigned EXT_HDR_BYTES   = 4;
  localparam int unsigned ALPN_MIN_LEN    = 3;
  localparam int unsigned ALPN_NAME_OFF   = 2;

endpackage

`default_nettype wire

### rtl/core/tlsalpn_if.sv
// valid/ready channel interfaces: reply bytes in, parse results out
// no dependencies
`default_nettype none

interface tlsalpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_reply;

  modport source (output valid, data_byte, byte_present, end_of_reply, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_reply, output ready);
endinterface

interface tlsalpn_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_kind;
  logic [7:0] version_major;
  logic [7:0] version_minor;
  logic [4:0] alpn_length;
  logic [7:0] alpn_char;
  logic       final_result;

  modport source (output valid, reply_kind, version_major, version_minor, alpn_length,
                  alpn_char, final_result, input ready);
  modport sink   (input valid, reply_kind, version_major, version_minor, alpn_length,
                  alpn_char, final_result, output ready);
endinterface

`default_nettype wire

### rtl/core/tlsalpn_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module tlsalpn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/tlsalpn_parser.sv
// input register, byte position tracking and extension walk for one reply
// depends on tlsalpn_pkg and tlsalpn_in_if; writes name bytes to tlsalpn_ram
`default_nettype none

module tlsalpn_parser import tlsalpn_pkg::*; #(
  parameter int unsigned ALPN_MAX      = 31,
  parameter int unsigned POSITION_BITS = 17,
  localparam int unsigned CW = $clog2(ALPN_MAX + 1),
  localparam int unsigned IW = (ALPN_MAX > 1) ? $clog2(ALPN_MAX) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlsalpn_in_if.sink    byte_i,
  input  logic          emit_busy_i,
  output reply_sum_t    sum_o,
  output logic [CW-1:0] sum_count_o,
  output logic          sum_bank_o,
  output logic          wr_en_o,
  output logic [IW:0]   wr_addr_o,
  output logic [7:0]    wr_data_o
);

  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned XW = ((PW > 16) ? PW : 16) + 2;

  typedef enum logic [3:0] {
    PH_HEAD, PH_EXTLEN_HI, PH_EXTLEN_LO, PH_EXT_HDR, PH_ALPN_PRE,
    PH_NAME, PH_WAIT_END, PH_SKIP, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE, ST_PENDING, ST_FOUND
  } status_e;

  // input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_pres_q;
  logic       in_last_q;
  logic       fire;
  logic       in_ready;
  logic       take;

  logic [PW-1:0] cnt_q, cnt_d;
  logic [7:0]    rtype_q, rtype_d, rver_q, rver_d, htype_q, htype_d;
  logic [7:0]    vmaj_q, vmaj_d, vmin_q, vmin_d;
  phase_e        phase_q, phase_d, mid;
  logic [PW-1:0] target_q, target_d;
  logic [PW-1:0] list_end_q, list_end_d;
  logic [15:0]   tl0_q, tl0_d, tl1_q, tl1_d;
  logic [CW-1:0] ncount_q, ncount_d;
  status_e       status_q, status_d;
  logic          bank_q;
  logic          tail;

  logic [PW-1:0] after;
  logic [PW-1:0] off;
  logic [15:0]   len_lo;
  logic [15:0]   el_hi;
  logic [XW-1:0] t_lo_x;
  logic [XW-1:0] t_hdr_x;
  logic          pre_hit;
  logic          end_cut;
  logic          hdr_short;
  logic          is_hello;
  logic          is_alert;

  assign fire     = in_v_q && (!in_last_q || !emit_busy_i);
  assign in_ready = !in_v_q || fire;
  assign byte_i.ready = in_ready;
  assign take     = fire && in_pres_q && (cnt_q != {PW{1'b1}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready) begin
      in_v_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && byte_i.valid) begin
      in_byte_q <= byte_i.data_byte;
      in_pres_q <= byte_i.byte_present;
      in_last_q <= byte_i.end_of_reply;
    end
  end

  assign after     = cnt_q + 1'b1;
  assign off       = cnt_q - target_q;
  assign len_lo    = {tl0_q[7:0], in_byte_q};
  assign el_hi     = {tl1_q[15:8], in_byte_q};
  assign t_lo_x    = XW'(after) + XW'(len_lo);
  assign t_hdr_x   = XW'(after) + XW'(el_hi);
  assign pre_hit   = (XW'(cnt_q) + XW'(tl1_q)) == (XW'(target_q) + XW'(ALPN_NAME_OFF));
  assign end_cut   = (XW'(target_q) + XW'(EXT_HDR_BYTES)) > XW'(list_end_q);
  assign hdr_short = (XW'(after) + XW'(EXT_HDR_BYTES)) > XW'(list_end_q);

  always_comb begin
    cnt_d      = cnt_q;
    rtype_d    = rtype_q;
    rver_d     = rver_q;
    htype_d    = htype_q;
    vmaj_d     = vmaj_q;
    vmin_d     = vmin_q;
    phase_d    = phase_q;
    target_d   = target_q;
    list_end_d = list_end_q;
    tl0_d      = tl0_q;
    tl1_d      = tl1_q;
    ncount_d   = ncount_q;
    status_d   = status_q;
    mid        = phase_q;
    tail       = 1'b0;
    wr_en_o    = 1'b0;
    if (take) begin
      if (cnt_q == PW'(POS_REC_TYPE)) rtype_d = in_byte_q;
      if (cnt_q == PW'(POS_REC_VER))  rver_d  = in_byte_q;
      if (cnt_q == PW'(POS_HS_TYPE))  htype_d = in_byte_q;
      if (cnt_q == PW'(POS_VER_MAJ))  vmaj_d  = in_byte_q;
      if (cnt_q == PW'(POS_VER_MIN))  vmin_d  = in_byte_q;
      unique case (phase_q)
        PH_HEAD: begin
          if (cnt_q == PW'(POS_SID_LEN)) begin
            target_d = PW'(SID_TO_LIST) + PW'(in_byte_q);
            phase_d  = PH_EXTLEN_HI;
          end
        end
        PH_EXTLEN_HI: begin
          if (cnt_q == target_q) begin
            tl0_d   = {8'h00, in_byte_q};
            phase_d = PH_EXTLEN_LO;
          end
        end
        PH_EXTLEN_LO: begin
          if (t_lo_x > XW'({PW{1'b1}})) begin
            phase_d = PH_DONE;
          end else begin
            list_end_d = t_lo_x[PW-1:0];
            if (len_lo < 16'(EXT_HDR_BYTES)) begin
              phase_d = PH_DONE;
            end else begin
              target_d = after;
              phase_d  = PH_EXT_HDR;
            end
          end
        end
        PH_EXT_HDR: begin
          if (off == PW'(0)) begin
            tl0_d = {in_byte_q, 8'h00};
          end else if (off == PW'(1)) begin
            tl0_d = {tl0_q[15:8], in_byte_q};
          end else if (off == PW'(2)) begin
            tl1_d = {in_byte_q, 8'h00};
          end else begin
            tl1_d = el_hi;
            if (t_hdr_x > XW'(list_end_q)) begin
              phase_d = PH_DONE;
            end else begin
              target_d = t_hdr_x[PW-1:0];
              if (tl0_q == EXT_TYPE_ALPN && el_hi >= 16'(ALPN_MIN_LEN)) begin
                phase_d = PH_ALPN_PRE;
              end else if (el_hi == 16'h0000) begin
                phase_d = hdr_short ? PH_DONE : PH_EXT_HDR;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_ALPN_PRE: begin
          tail = 1'b1;
          if (pre_hit) begin
            if (17'(in_byte_q) + 17'(ALPN_MIN_LEN) <= 17'(tl1_q)) begin
              ncount_d = '0;
              status_d = ST_PENDING;
              tl0_d    = {8'h00, in_byte_q};
              mid      = (in_byte_q != 8'h00) ? PH_NAME : PH_WAIT_END;
            end else begin
              mid = PH_SKIP;
            end
          end
        end
        PH_NAME: begin
          tail = 1'b1;
          if (ncount_q < CW'(ALPN_MAX)) begin
            wr_en_o  = 1'b1;
            ncount_d = ncount_q + 1'b1;
          end
          tl0_d = tl0_q - 16'd1;
          if (tl0_q == 16'd1) mid = PH_WAIT_END;
        end
        PH_WAIT_END, PH_SKIP: begin
          tail = 1'b1;
        end
        default: ;
      endcase
      if (tail) begin
        phase_d = mid;
        if (after == target_q) begin
          if (mid == PH_WAIT_END) begin
            status_d = ST_FOUND;
            phase_d  = PH_DONE;
          end else if (mid == PH_SKIP) begin
            phase_d = end_cut ? PH_DONE : PH_EXT_HDR;
          end
        end
      end
      cnt_d = after;
    end
  end

  assign wr_addr_o = {bank_q, ncount_q[IW-1:0]};
  assign wr_data_o = in_byte_q;

  // classification on the state as it stands after the final byte
  assign is_hello = (cnt_d >= PW'(MIN_HELLO_BYTES)) && (rtype_d == REC_HANDSHAKE) &&
                    (rver_d == REC_VER_TLS || rver_d == REC_VER_SSL) &&
                    (htype_d == HS_SERVER_HELLO);
  assign is_alert = (cnt_d >= PW'(MIN_ALERT_BYTES)) && (rtype_d == REC_ALERT);

  always_comb begin
    sum_o.valid     = fire && in_last_q;
    sum_o.kind      = KIND_NONE;
    sum_o.ver_major = 8'h00;
    sum_o.ver_minor = 8'h00;
    sum_count_o     = '0;
    if (is_hello) begin
      sum_o.kind      = KIND_HELLO;
      sum_o.ver_major = vmaj_d;
      sum_o.ver_minor = vmin_d;
      if (cnt_d >= PW'(MIN_EXT_BYTES) && status_d == ST_FOUND) sum_count_o = ncount_d;
    end else if (is_alert) begin
      sum_o.kind = KIND_ALERT;
    end
  end

  assign sum_bank_o = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rtype_q    <= 8'h00;
      rver_q     <= 8'h00;
      htype_q    <= 8'h00;
      vmaj_q     <= 8'h00;
      vmin_q     <= 8'h00;
      phase_q    <= PH_HEAD;
      target_q   <= '0;
      list_end_q <= '0;
      tl0_q      <= 16'h0000;
      tl1_q      <= 16'h0000;
      ncount_q   <= '0;
      status_q   <= ST_NONE;
      bank_q     <= 1'b0;
    end else if (fire && in_last_q) begin
      cnt_q      <= '0;
      rtype_q    <= 8'h00;
      rver_q     <= 8'h00;
      htype_q    <= 8'h00;
      vmaj_q     <= 8'h00;
      vmin_q     <= 8'h00;
      phase_q    <= PH_HEAD;
      target_q   <= '0;
      list_end_q <= '0;
      tl0_q      <= 16'h0000;
      tl1_q      <= 16'h0000;
      ncount_q   <= '0;
      status_q   <= ST_NONE;
      bank_q     <= ~bank_q;
    end else begin
      cnt_q      <= cnt_d;
      rtype_q    <= rtype_d;
      rver_q     <= rver_d;
      htype_q    <= htype_d;
      vmaj_q     <= vmaj_d;
      vmin_q     <= vmin_d;
      phase_q    <= phase_d;
      target_q   <= target_d;
      list_end_q <= list_end_d;
      tl0_q      <= tl0_d;
      tl1_q      <= tl1_d;
      ncount_q   <= ncount_d;
      status_q   <= status_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tlsalpn_emitter.sv
// result sequencer: reads captured name bytes back and drives the output register
// depends on tlsalpn_pkg and tlsalpn_out_if; reads tlsalpn_ram
`default_nettype none

module tlsalpn_emitter import tlsalpn_pkg::*; #(
  parameter int unsigned ALPN_MAX = 31,
  localparam int unsigned CW = $clog2(ALPN_MAX + 1),
  localparam int unsigned IW = (ALPN_MAX > 1) ? $clog2(ALPN_MAX) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  reply_sum_t    sum_i,
  input  logic [CW-1:0] sum_count_i,
  input  logic          sum_bank_i,
  output logic [IW:0]   rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output logic          busy_o,
  tlsalpn_out_if.source result_o
);

  logic          run_q, run_d;
  logic          rd_ok_q, rd_ok_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] n_q;
  logic          bank_q;
  reply_kind_e   kind_q;
  logic [7:0]    vmaj_q, vmin_q;

  logic          out_v_q;
  reply_kind_e   o_kind_q;
  logic [7:0]    o_vmaj_q, o_vmin_q, o_char_q;
  logic [4:0]    o_len_q;
  logic          o_final_q;

  logic          out_free;
  logic          cand;
  logic          load;
  logic          last_item;
  logic [CW+4:0] n_ext;

  assign out_free  = !out_v_q || result_o.ready;
  assign cand      = run_q && ((n_q == '0) || rd_ok_q);
  assign load      = cand && out_free;
  assign last_item = (n_q == '0) || ((k_q + 1'b1) == n_q);
  assign n_ext     = {5'b00000, n_q};

  always_comb begin
    run_d = run_q;
    k_d   = k_q;
    if (sum_i.valid) begin
      run_d = 1'b1;
      k_d   = '0;
    end else if (load) begin
      k_d = k_q + 1'b1;
      if (last_item) run_d = 1'b0;
    end
  end

  // read data is good once the address has passed the ram read register while running
  assign rd_ok_d   = run_q && run_d;
  assign rd_addr_o = {bank_q, k_d[IW-1:0]};
  assign busy_o    = run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      rd_ok_q <= 1'b0;
      k_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      run_q   <= run_d;
      rd_ok_q <= rd_ok_d;
      k_q     <= k_d;
      if (out_free) out_v_q <= cand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_i.valid) begin
      kind_q <= sum_i.kind;
      vmaj_q <= sum_i.ver_major;
      vmin_q <= sum_i.ver_minor;
      n_q    <= sum_count_i;
      bank_q <= sum_bank_i;
    end
    if (load) begin
      o_kind_q  <= kind_q;
      o_vmaj_q  <= vmaj_q;
      o_vmin_q  <= vmin_q;
      o_len_q   <= n_ext[4:0];
      o_char_q  <= (n_q == '0) ? 8'h00 : rd_data_i;
      o_final_q <= last_item;
    end
  end

  assign result_o.valid         = out_v_q;
  assign result_o.reply_kind    = o_kind_q;
  assign result_o.version_major = o_vmaj_q;
  assign result_o.version_minor = o_vmin_q;
  assign result_o.alpn_length   = o_len_q;
  assign result_o.alpn_char     = o_char_q;
  assign result_o.final_result  = o_final_q;

endmodule

`default_nettype wire

### rtl/core/tls_server_hello_alpn_parser.sv
// top level of the server hello / alpn reply parser
// depends on tlsalpn_pkg, tlsalpn_if, tlsalpn_ram, tlsalpn_parser, tlsalpn_emitter
//
//   port      dir  moves                              accepted when
//   byte_i    in   one reply byte request + markers   valid && ready
//   result_o  out  one result (kind, version, char)   valid && ready
//
// each byte request is registered, parsed and retired; one per cycle unless it must wait
// results leave via an output register, one per cycle while ready, 1 to ALPN_MAX per reply
// a final request waits while the previous reply's results are still being read out
// name bytes sit in a two-bank ram so the next reply is parsed during read-out
// reset is asynchronous active low and returns the parser to waiting for a header
`default_nettype none
`include "assert_macros.svh"

module tls_server_hello_alpn_parser import tlsalpn_pkg::*; #(
  parameter int unsigned ALPN_MAX      = 31,
  parameter int unsigned POSITION_BITS = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlsalpn_in_if.sink    byte_i,
  tlsalpn_out_if.source result_o
);

  localparam int unsigned CW = $clog2(ALPN_MAX + 1);
  localparam int unsigned IW = (ALPN_MAX > 1) ? $clog2(ALPN_MAX) : 1;

  reply_sum_t    sum;
  logic [CW-1:0] sum_count;
  logic          sum_bank;
  logic          emit_busy;
  logic          wr_en;
  logic [IW:0]   wr_addr;
  logic [7:0]    wr_data;
  logic [IW:0]   rd_addr;
  logic [7:0]    rd_data;

  tlsalpn_parser #(
    .ALPN_MAX      (ALPN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .emit_busy_i (emit_busy),
    .sum_o       (sum),
    .sum_count_o (sum_count),
    .sum_bank_o  (sum_bank),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  tlsalpn_ram #(
    .WIDTH (8),
    .DEPTH (2 ** (IW + 1))
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tlsalpn_emitter #(
    .ALPN_MAX (ALPN_MAX)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_i       (sum),
    .sum_count_i (sum_count),
    .sum_bank_i  (sum_bank),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .busy_o      (emit_busy),
    .result_o    (result_o)
  );

  `ASSERT_NEVER(a_sum_while_busy, clk_i, rst_ni, sum.valid && emit_busy, "reply summary while emitting")
  `ASSERT_ALWAYS(a_multi_is_hello, clk_i, rst_ni, result_o.valid && !result_o.final_result |-> result_o.reply_kind == KIND_HELLO, "multi result run for non hello")
  `ASSERT_ALWAYS(a_non_hello_zero, clk_i, rst_ni, result_o.valid && result_o.reply_kind != KIND_HELLO |-> result_o.version_major == 8'h00 && result_o.alpn_length == 5'd0, "non hello carries data")
  `ASSERT_ALWAYS(a_run_kind_holds, clk_i, rst_ni, result_o.valid && result_o.ready && !result_o.final_result |=> $stable(result_o.reply_kind), "kind changed inside a run")

endmodule

`default_nettype wire

### verif/tlsalpn_tb_pkg.sv
// scoreboard for the server hello / alpn parser testbench: predicts the results of each reply
// depends on tlsalpn_pkg
`timescale 1ns / 100ps

package tlsalpn_tb_pkg;
  import tlsalpn_pkg::*;

  localparam int unsigned NAME_LIMIT = 31;
  localparam int unsigned POS_LIMIT  = (1 << 17) - 1;

  typedef enum int unsigned {
    WALK_HEADER,
    WALK_LIST_HI,
    WALK_LIST_LO,
    WALK_EXT_HDR,
    WALK_ALPN_PRE,
    WALK_NAME,
    WALK_WAIT_END,
    WALK_SKIP,
    WALK_DONE
  } walk_phase_e;

  typedef enum int unsigned {
    NAME_NONE,
    NAME_PENDING,
    NAME_FOUND
  } name_state_e;

  typedef struct packed {
    reply_kind_e kind;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
    logic [4:0]  name_len;
    logic [7:0]  name_char;
    logic        last;
  } alpn_result_t;

  class reply_checker;
    int unsigned  nbytes;
    logic [7:0]   head [3];
    logic [7:0]   ver [2];
    walk_phase_e  phase;
    int unsigned  target;
    int unsigned  list_end;
    logic [15:0]  ext_tl [2];
    logic [7:0]   name_buf [NAME_LIMIT];
    int unsigned  name_cnt;
    name_state_e  status;
    alpn_result_t results_due [$];
    int unsigned  errors;
    int unsigned  results_seen;

    function new();
      errors = 0;
      results_seen = 0;
      clear();
    endfunction

    function void clear();
      nbytes = 0;
      foreach (head[k]) head[k] = '0;
      foreach (ver[k]) ver[k] = '0;
      phase = WALK_HEADER;
      target = 0;
      list_end = 0;
      ext_tl[0] = '0;
      ext_tl[1] = '0;
      foreach (name_buf[k]) name_buf[k] = '0;
      name_cnt = 0;
      status = NAME_NONE;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    function void open_ext(int unsigned pos);
      if (pos + EXT_HDR_BYTES > list_end) begin
        phase = WALK_DONE;
      end else begin
        target = pos;
        phase = WALK_EXT_HDR;
      end
    endfunction

    // follows session id, cipher, compression and extension list byte by byte
    function void walk_extensions(int unsigned i, logic [7:0] b);
      int unsigned after;
      int unsigned off;
      int unsigned el;
      int unsigned t;
      after = i + 1;
      case (phase)
        WALK_HEADER: begin
          if (i == POS_SID_LEN) begin
            target = SID_TO_LIST + b;
            phase = WALK_LIST_HI;
          end
          return;
        end
        WALK_LIST_HI: begin
          if (i == target) begin
            ext_tl[0] = {8'h00, b};
            phase = WALK_LIST_LO;
          end
          return;
        end
        WALK_LIST_LO: begin
          t = after + {ext_tl[0][7:0], b};
          if (t > POS_LIMIT) begin
            phase = WALK_DONE;
            return;
          end
          list_end = t;
          open_ext(after);
          return;
        end
        WALK_EXT_HDR: begin
          off = i - target;
          if (off == 0) begin
            ext_tl[0] = {b, 8'h00};
          end else if (off == 1) begin
            ext_tl[0] = ext_tl[0] | {8'h00, b};
          end else if (off == 2) begin
            ext_tl[1] = {b, 8'h00};
          end else begin
            ext_tl[1] = ext_tl[1] | {8'h00, b};
            el = ext_tl[1];
            t = after + el;
            if (t > list_end) begin
              phase = WALK_DONE;
              return;
            end
            target = t;
            if (ext_tl[0] == EXT_TYPE_ALPN && el >= ALPN_MIN_LEN) begin
              phase = WALK_ALPN_PRE;
            end else if (el == 0) begin
              open_ext(t);
            end else begin
              phase = WALK_SKIP;
            end
          end
          return;
        end
        WALK_ALPN_PRE: begin
          el = ext_tl[1];
          off = i - (target - el);
          if (off == ALPN_NAME_OFF) begin
            if (ALPN_MIN_LEN + b <= el) begin
              name_cnt = 0;
              status = NAME_PENDING;
              ext_tl[0] = {8'h00, b};
              phase = (b != 0) ? WALK_NAME : WALK_WAIT_END;
            end else begin
              phase = WALK_SKIP;
            end
          end
        end
        WALK_NAME: begin
          if (name_cnt < NAME_LIMIT) begin
            name_buf[name_cnt] = b;
            name_cnt++;
          end
          ext_tl[0] = ext_tl[0] - 16'd1;
          if (ext_tl[0] == 16'd0) phase = WALK_WAIT_END;
        end
        WALK_WAIT_END, WALK_SKIP: begin
        end
        default: return;
      endcase
      if (after == target) begin
        if (phase == WALK_WAIT_END) begin
          status = NAME_FOUND;
          phase = WALK_DONE;
        end else if (phase == WALK_SKIP) begin
          open_ext(target);
        end
      end
    endfunction

    function void take_byte(logic [7:0] b, logic present, logic end_mark);
      reply_kind_e  kind;
      logic [7:0]   vmaj;
      logic [7:0]   vmin;
      int unsigned  n;
      alpn_result_t r;
      if (present && nbytes < POS_LIMIT) begin
        case (nbytes)
          POS_REC_TYPE: head[0] = b;
          POS_REC_VER:  head[1] = b;
          POS_HS_TYPE:  head[2] = b;
          POS_VER_MAJ:  ver[0] = b;
          POS_VER_MIN:  ver[1] = b;
          default: ;
        endcase
        walk_extensions(nbytes, b);
        nbytes++;
      end
      if (!end_mark) return;
      kind = KIND_NONE;
      vmaj = '0;
      vmin = '0;
      n = 0;
      if (nbytes >= MIN_HELLO_BYTES && head[0] == REC_HANDSHAKE &&
          (head[1] == REC_VER_TLS || head[1] == REC_VER_SSL) && head[2] == HS_SERVER_HELLO) begin
        kind = KIND_HELLO;
        vmaj = ver[0];
        vmin = ver[1];
        if (nbytes >= MIN_EXT_BYTES && status == NAME_FOUND) n = name_cnt;
      end else if (nbytes >= MIN_ALERT_BYTES && head[0] == REC_ALERT) begin
        kind = KIND_ALERT;
      end
      if (n == 0) begin
        r = '{kind: kind, ver_major: vmaj, ver_minor: vmin, name_len: 5'd0, name_char: 8'd0,
              last: 1'b1};
        results_due.push_back(r);
      end else begin
        for (int unsigned k = 0; k < n; k++) begin
          r = '{kind: kind, ver_major: vmaj, ver_minor: vmin, name_len: 5'(n),
                name_char: name_buf[k], last: (k + 1 == n)};
          results_due.push_back(r);
        end
      end
      clear();
    endfunction

    function void check_result(alpn_result_t got);
      alpn_result_t want;
      results_seen++;
      if (results_due.size() == 0) begin
        $error("unexpected result: reply_kind %0d alpn_char %0h", got.kind, got.name_char);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.kind !== want.kind) begin
        $error("reply_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.ver_major !== want.ver_major) begin
        $error("version_major: expected %0h, got %0h", want.ver_major, got.ver_major);
        errors++;
      end
      if (got.ver_minor !== want.ver_minor) begin
        $error("version_minor: expected %0h, got %0h", want.ver_minor, got.ver_minor);
        errors++;
      end
      if (got.name_len !== want.name_len) begin
        $error("alpn_length: expected %0d, got %0d", want.name_len, got.name_len);
        errors++;
      end
      if (got.name_char !== want.name_char) begin
        $error("alpn_char: expected %0h, got %0h", want.name_char, got.name_char);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("final_result: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function void check_drained();
      if (results_due.size() != 0) begin
        $error("%0d results never arrived", results_due.size());
        errors++;
      end
    endfunction
  endclass

endpackage

### verif/tls_server_hello_alpn_parser_tb.sv
// top of the server hello / alpn parser testbench: directed and random replies, random idling
// depends on tlsalpn_pkg, tlsalpn_if, tlsalpn_tb_pkg and the parser rtl
`timescale 1ns / 100ps

module tls_server_hello_alpn_parser_tb;
  import tlsalpn_pkg::*;
  import tlsalpn_tb_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int unsigned items_sent;

  tlsalpn_in_if  byte_if ();
  tlsalpn_out_if res_if ();

  reply_checker sb = new();

  tls_server_hello_alpn_parser u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic byte_q_t hello_head(logic [7:0] rec_ver, logic [7:0] hs_type, int sid_len);
    byte_q_t q;
    q.push_back(REC_HANDSHAKE);
    q.push_back(rec_ver);
    repeat (3) q.push_back(rnd_byte());
    q.push_back(hs_type);
    repeat (37) q.push_back(rnd_byte());
    q.push_back(8'(sid_len));
    repeat (sid_len + 3) q.push_back(rnd_byte());
    return q;
  endfunction

  function automatic byte_q_t alpn_body(int declared, int actual, int extra);
    byte_q_t q;
    int list_len;
    list_len = 1 + actual + extra;
    q.push_back(8'(list_len >> 8));
    q.push_back(8'(list_len));
    q.push_back(8'(declared));
    repeat (actual + extra) q.push_back(rnd_byte());
    return q;
  endfunction

  function automatic void add_ext(ref byte_q_t q, input logic [15:0] ext_type,
                                  input byte_q_t body);
    q.push_back(ext_type[15:8]);
    q.push_back(ext_type[7:0]);
    q.push_back(8'(body.size() >> 8));
    q.push_back(8'(body.size()));
    foreach (body[k]) q.push_back(body[k]);
  endfunction

  function automatic void close_list(ref byte_q_t q, input byte_q_t exts, input int delta);
    int len;
    len = exts.size() + delta;
    if (len < 0) len = 0;
    q.push_back(8'(len >> 8));
    q.push_back(8'(len));
    foreach (exts[k]) q.push_back(exts[k]);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic present, input logic end_mark);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid        = 1'b1;
    byte_if.data_byte    = b;
    byte_if.byte_present = present;
    byte_if.end_of_reply = end_mark;
    do @(posedge clk_i); while (!byte_if.ready);
    sb.take_byte(b, present, end_mark);
    if (present) items_sent++;
  endtask

  task automatic send_reply(input byte_q_t q, input bit absent_end);
    foreach (q[k]) begin
      if (!calm && $urandom_range(0, 31) == 0) push_byte(rnd_byte(), 1'b0, 1'b0);
      push_byte(q[k], 1'b1, (k == q.size() - 1) && !absent_end);
    end
    if (absent_end || q.size() == 0) push_byte(rnd_byte(), 1'b0, 1'b1);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    byte_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    byte_q_t q;
    byte_q_t exts;
    byte_q_t none;
    byte_q_t body;
    // empty reply
    q = {};
    send_reply(q, 1'b1);
    q = {REC_ALERT, 8'h02};
    send_reply(q, 1'b0);
    q = {REC_ALERT};
    send_reply(q, 1'b0);
    // shortest hello, ssl record version
    q = hello_head(REC_VER_SSL, HS_SERVER_HELLO, 0);
    while (q.size() > MIN_HELLO_BYTES) void'(q.pop_back());
    q[POS_VER_MAJ] = 8'hff;
    q[POS_VER_MIN] = 8'h00;
    send_reply(q, 1'b0);
    q = hello_head(REC_VER_TLS, HS_SERVER_HELLO, 0);
    while (q.size() > MIN_HELLO_BYTES - 1) void'(q.pop_back());
    send_reply(q, 1'b0);
    q = hello_head(REC_VER_TLS, 8'h01, 0);
    while (q.size() > MIN_HELLO_BYTES + 1) void'(q.pop_back());
    send_reply(q, 1'b1);
    q = hello_head(8'h04, HS_SERVER_HELLO, 0);
    while (q.size() > MIN_HELLO_BYTES + 1) void'(q.pop_back());
    send_reply(q, 1'b0);
    // empty name
    q = hello_head(REC_VER_TLS, HS_SERVER_HELLO, 1);
    exts = {};
    add_ext(exts, EXT_TYPE_ALPN, alpn_body(0, 0, 0));
    close_list(q, exts, 0);
    send_reply(q, 1'b1);
    // bad name length and too short a body before a name longer than the store
    q = hello_head(REC_VER_TLS, HS_SERVER_HELLO, 0);
    exts = {};
    add_ext(exts, EXT_TYPE_ALPN, alpn_body(9, 2, 0));
    body = {8'h00, 8'h01};
    add_ext(exts, EXT_TYPE_ALPN, body);
    add_ext(exts, EXT_TYPE_ALPN, alpn_body(NAME_LIMIT + 2, NAME_LIMIT + 2, 0));
    close_list(q, exts, 0);
    send_reply(q, 1'b0);
    // empty extension, then alpn cut short by the end of the reply
    q = hello_head(REC_VER_TLS, HS_SERVER_HELLO, 0);
    exts = {};
    add_ext(exts, 16'h0000, none);
    add_ext(exts, EXT_TYPE_ALPN, alpn_body(3, 3, 0));
    close_list(q, exts, 0);
    void'(q.pop_back());
    send_reply(q, 1'b0);
  endtask

  task automatic random_reply();
    byte_q_t q;
    byte_q_t exts;
    byte_q_t body;
    int pick;
    int nl;
    int delta;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      q = hello_head(($urandom_range(0, 3) == 0) ? REC_VER_SSL : REC_VER_TLS,
                     ($urandom_range(0, 15) == 0) ? rnd_byte() : HS_SERVER_HELLO,
                     $urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
      exts = {};
      repeat ($urandom_range(0, 3)) begin
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) nl = 0;
        else if ($urandom_range(0, 9) == 0) nl = $urandom_range(28, 45);
        else nl = $urandom_range(1, 8);
        if (pick < 5) begin
          add_ext(exts, EXT_TYPE_ALPN,
                  alpn_body(nl, nl, $urandom_range(0, 1) ? 0 : $urandom_range(1, 6)));
        end else if (pick == 5) begin
          add_ext(exts, EXT_TYPE_ALPN, alpn_body(nl + $urandom_range(1, 4), nl, 0));
        end else begin
          body = {};
          repeat ($urandom_range(0, (pick == 6) ? 2 : 6)) body.push_back(rnd_byte());
          add_ext(exts, (pick == 6) ? EXT_TYPE_ALPN : {rnd_byte(), rnd_byte()}, body);
        end
      end
      delta = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 12)) - 6 : 0;
      close_list(q, exts, delta);
      repeat ($urandom_range(0, 3)) q.push_back(rnd_byte());
      if ($urandom_range(0, 7) == 0) begin
        nl = $urandom_range(40, q.size() - 1);
        while (q.size() > nl) void'(q.pop_back());
      end
    end else if (pick == 7) begin
      q = {REC_ALERT};
      repeat ($urandom_range(0, 6)) q.push_back(rnd_byte());
    end else begin
      q = {};
      repeat ($urandom_range(0, 20)) q.push_back(rnd_byte());
      if (q.size() != 0 && $urandom_range(0, 1)) q[0] = REC_HANDSHAKE;
    end
    send_reply(q, $urandom_range(0, 5) == 0);
  endtask

  initial begin
    calm = 1'b0;
    items_sent = 0;
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.byte_present = 1'b0;
    byte_if.end_of_reply = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    drain_results();

    while (items_sent < 300) begin
      random_reply();
      if ($urandom_range(0, 11) == 0) drain_results();
    end

    calm = 1'b1;
    random_reply();

    drain_results();
    repeat (32) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result('{kind: reply_kind_e'(res_if.reply_kind),
                        ver_major: res_if.version_major,
                        ver_minor: res_if.version_minor,
                        name_len: res_if.alpn_length,
                        name_char: res_if.alpn_char,
                        last: res_if.final_result});
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### tls_server_hello_alpn_parser.f
+incdir+rtl/core
rtl/core/tlsalpn_pkg.sv
rtl/core/tlsalpn_if.sv
rtl/core/tlsalpn_ram.sv
rtl/core/tlsalpn_parser.sv
rtl/core/tlsalpn_emitter.sv
rtl/core/tls_server_hello_alpn_parser.sv
verif/tlsalpn_tb_pkg.sv
verif/tls_server_hello_alpn_parser_tb.sv
